// ===== rtl/arf_pkg.sv =====
package arf_pkg;

	localparam int unsigned POS_W = 6;
	localparam int unsigned IP_W = 32;
	localparam int unsigned MAC_W = 48;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
	localparam logic [15:0] ARP_OP_REPLY = 16'h0002;

	localparam logic [POS_W-1:0] POS_ETYPE_HI = 6'd12;
	localparam logic [POS_W-1:0] POS_ETYPE_LO = 6'd13;
	localparam logic [POS_W-1:0] POS_OP_HI = 6'd20;
	localparam logic [POS_W-1:0] POS_OP_LO = 6'd21;
	localparam logic [POS_W-1:0] POS_SHA_FIRST = 6'd22;
	localparam logic [POS_W-1:0] POS_SHA_LAST = 6'd27;
	localparam logic [POS_W-1:0] POS_SPA_FIRST = 6'd28;
	localparam logic [POS_W-1:0] POS_SPA_LAST = 6'd31;
	localparam logic [POS_W-1:0] POS_TPA_FIRST = 6'd38;
	localparam logic [POS_W-1:0] POS_TPA_LAST = 6'd41;
	localparam logic [POS_W-1:0] FRAME_MIN = 6'd42;

	localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SOUGHT_IP = 2'd1;

	typedef struct packed {
		logic check;
		logic [7:0] value;
	} byte_chk_t;

	function automatic logic [7:0] ip_byte(input logic [IP_W-1:0] ip, input logic [1:0] k);
		logic [IP_W-1:0] sh;
		sh = ip >> {~k, 3'b000};
		return sh[7:0];
	endfunction

	function automatic byte_chk_t expected_byte(
		input logic [POS_W-1:0] pos,
		input logic [IP_W-1:0] local_ip,
		input logic [IP_W-1:0] sought_ip
	);
		byte_chk_t r;
		logic [POS_W-1:0] tpa_off;
		tpa_off = pos - POS_TPA_FIRST;
		r.check = 1'b1;
		r.value = 8'd0;
		case (pos) inside
			POS_ETYPE_HI: r.value = ETHERTYPE_ARP[15:8];
			POS_ETYPE_LO: r.value = ETHERTYPE_ARP[7:0];
			POS_OP_HI: r.value = ARP_OP_REPLY[15:8];
			POS_OP_LO: r.value = ARP_OP_REPLY[7:0];
			[POS_SPA_FIRST:POS_SPA_LAST]: r.value = ip_byte(sought_ip, pos[1:0]);
			[POS_TPA_FIRST:POS_TPA_LAST]: r.value = ip_byte(local_ip, tpa_off[1:0]);
			default: r.check = 1'b0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/arp_reply_filter.sv =====
// channel | valid    | stall     | payload
// input   | in_valid | in_stall  | frame_byte, last_byte
// output  | out_valid| out_stall | matched, sender_mac
// config  | cfg_we   | -         | cfg_index, cfg_data
//
// one byte per cycle sustained while in_stall stays low; the result register loads from the input
// register once it holds the last byte and no held result blocks it
// a byte sits in the input register while it updates position, check flag and mac
// in_stall rises only when a last byte waits in the input register behind a held result
// reset clears position, mac, address registers and both valid flags, and sets the check flag
module arp_reply_filter import arf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           frame_byte,
	input  logic                 last_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 matched,
	output logic [MAC_W-1:0]     sender_mac,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [IP_W-1:0]      cfg_data
);

	logic [IP_W-1:0]  local_ip_q;
	logic [IP_W-1:0]  sought_ip_q;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;

	logic [POS_W-1:0] pos_q;
	logic             ok_q;
	logic [MAC_W-1:0] mac_q;

	logic             out_valid_q;
	logic             matched_q;
	logic [MAC_W-1:0] mac_out_q;

	logic             advance;
	logic             step;
	byte_chk_t        chk;
	logic [POS_W-1:0] pos_nxt;
	logic             ok_nxt;
	logic [MAC_W-1:0] mac_nxt;
	logic             hit;

	// config decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q  <= '0;
			sought_ip_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LOCAL_IP:  local_ip_q  <= cfg_data;
				CFG_SOUGHT_IP: sought_ip_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance  = !(last_s1 && out_valid_q && out_stall);
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= frame_byte;
			last_s1 <= last_byte;
		end
	end

	always_comb begin
		chk     = expected_byte(pos_q, local_ip_q, sought_ip_q);
		pos_nxt = pos_q;
		ok_nxt  = ok_q;
		mac_nxt = mac_q;
		if (pos_q < FRAME_MIN) begin
			pos_nxt = pos_q + 6'd1;
			if (chk.check && chk.value != byte_s1) begin
				ok_nxt = 1'b0;
			end
			if (pos_q >= POS_SHA_FIRST && pos_q <= POS_SHA_LAST) begin
				mac_nxt = {mac_q[MAC_W-9:0], byte_s1};
			end
		end
		hit = ok_nxt && (pos_nxt >= FRAME_MIN);
	end

	// per-frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ok_q  <= 1'b1;
			mac_q <= '0;
		end else if (step) begin
			if (last_s1) begin
				pos_q <= '0;
				ok_q  <= 1'b1;
				mac_q <= '0;
			end else begin
				pos_q <= pos_nxt;
				ok_q  <= ok_nxt;
				mac_q <= mac_nxt;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			matched_q <= hit;
			mac_out_q <= hit ? mac_nxt : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign matched    = matched_q;
	assign sender_mac = mac_out_q;

endmodule

// ===== rtl/arf_checker.sv =====
module arf_props import arf_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             last_byte,
	input logic             out_valid,
	input logic             out_stall,
	input logic             matched,
	input logic [MAC_W-1:0] sender_mac
);

	// held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(matched) && $stable(sender_mac))
		else $error("result changed while stalled");

	// no match means no mac
	a_mac_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !matched |-> sender_mac == '0)
		else $error("mac shown on a non-matching frame");

	// input backpressure only comes from a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

	// a fresh result follows a last-byte transfer at the input
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall && last_byte, 2))
		else $error("result without a frame end");

endmodule

bind arp_reply_filter arf_props u_arf_props (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.last_byte  (last_byte),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.matched    (matched),
	.sender_mac (sender_mac)
);
